// File: sv/crss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crss_pkg;

  localparam int FREQ_W     = 22;
  localparam int BUS_W      = 16;
  localparam int RATIO_W    = 6;
  localparam int IDX_W      = 3;
  localparam int NUM_STATES = 8;
  localparam int CTRL_W     = 13;
  localparam int PORT_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [FREQ_W-1:0]    freq_t;
  typedef logic [RATIO_W-1:0]   ratio_t;
  typedef logic [IDX_W-1:0]     state_idx_t;
  typedef logic [NUM_STATES-1:0] state_mask_t;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_FREQ     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATIO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVER_READY = 2'd2;

  localparam ratio_t MAX_RATIO_RESET = 6'd60;

  // Action codes.
  localparam logic ACT_VERIFY = 1'b0;
  localparam logic ACT_APPLY  = 1'b1;

  // Policy modes.
  localparam logic [1:0] MODE_POWERSAVE   = 2'd0;
  localparam logic [1:0] MODE_PERFORMANCE = 2'd1;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_READY  = 2'd1;
  localparam logic [1:0] ST_RATIO_HIGH = 2'd2;
  localparam logic [1:0] ST_NO_ACTION  = 2'd3;

  // Fixed states: the lowest and highest ratio entries.
  localparam state_idx_t IDX_LOWEST  = 3'd4;
  localparam state_idx_t IDX_HIGHEST = 3'd6;

  localparam logic [CTRL_W-1:0] CTRL_FIXED = 13'h1600;
  localparam logic [3:0]        PORT_KEEP  = 4'hF;

  typedef struct packed {
    logic                action;
    freq_t               low_freq;
    freq_t               high_freq;
    logic [1:0]          policy_mode;
    logic [PORT_W-1:0]   port_read;
  } req_t;

  typedef struct packed {
    freq_t               out_low;
    freq_t               out_high;
    state_idx_t          state_index;
    logic [CTRL_W-1:0]   control_word;
    freq_t               old_freq;
    freq_t               new_freq;
    logic                write_port;
    logic [1:0]          status;
  } rsp_t;

  // Configuration and the per-state frequencies derived from it.
  typedef struct packed {
    logic [BUS_W-1:0]             bus_freq;
    ratio_t                       max_ratio;
    logic                         driver_ready;
    freq_t [NUM_STATES-1:0]       state_freq;
    freq_t                        bound_min;
    freq_t                        bound_max;
  } cfg_t;

  // Clock ratio of each state, in tenths.
  function automatic ratio_t ratio_of(state_idx_t idx);
    ratio_t r;
    case (idx)
      3'd0:    r = 6'd45;
      3'd1:    r = 6'd50;
      3'd2:    r = 6'd40;
      3'd3:    r = 6'd55;
      3'd4:    r = 6'd20;
      3'd5:    r = 6'd30;
      3'd6:    r = 6'd60;
      3'd7:    r = 6'd35;
      default: r = 6'd20;
    endcase
    return r;
  endfunction

  // State index holding the rank-th smallest ratio.
  function automatic state_idx_t asc_index(state_idx_t rank);
    state_idx_t idx;
    case (rank)
      3'd0:    idx = 3'd4;
      3'd1:    idx = 3'd5;
      3'd2:    idx = 3'd7;
      3'd3:    idx = 3'd2;
      3'd4:    idx = 3'd0;
      3'd5:    idx = 3'd1;
      3'd6:    idx = 3'd3;
      3'd7:    idx = 3'd6;
      default: idx = 3'd6;
    endcase
    return idx;
  endfunction

  // Lowest-ratio state in the mask, or dflt when the mask is empty.
  function automatic state_idx_t pick_lowest(state_mask_t mask, state_idx_t dflt);
    state_idx_t j;
    j = dflt;
    for (int r = NUM_STATES - 1; r >= 0; r--) begin
      if (mask[asc_index(IDX_W'(r))]) begin
        j = asc_index(IDX_W'(r));
      end
    end
    return j;
  endfunction

  // Highest-ratio state in the mask, or dflt when the mask is empty.
  function automatic state_idx_t pick_highest(state_mask_t mask, state_idx_t dflt);
    state_idx_t j;
    j = dflt;
    for (int r = 0; r < NUM_STATES; r++) begin
      if (mask[asc_index(IDX_W'(r))]) begin
        j = asc_index(IDX_W'(r));
      end
    end
    return j;
  endfunction

  // Index of the set bit of a one-hot mask.
  function automatic state_idx_t onehot_index(state_mask_t mask);
    state_idx_t j;
    j = '0;
    for (int k = 0; k < NUM_STATES; k++) begin
      if (mask[k]) begin
        j = j | IDX_W'(k);
      end
    end
    return j;
  endfunction

endpackage

`default_nettype wire

// File: sv/crss_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module crss_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [crss_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire logic [crss_pkg::CFG_DATA_W-1:0]     wr_data,
  output crss_pkg::cfg_t                           cfg
);
  import crss_pkg::*;

  logic [BUS_W-1:0]       bus_freq;
  ratio_t                 max_ratio;
  logic                   driver_ready;
  freq_t [NUM_STATES-1:0] state_freq;
  freq_t                  bound_min;
  freq_t                  bound_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_freq     <= '0;
      max_ratio    <= MAX_RATIO_RESET;
      driver_ready <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_BUS_FREQ:     bus_freq     <= wr_data[BUS_W-1:0];
        CFG_MAX_RATIO:    max_ratio    <= wr_data[RATIO_W-1:0];
        CFG_DRIVER_READY: driver_ready <= wr_data[0];
        default:          ;
      endcase
    end
  end

  // Scaled state table, refreshed every cycle; all products fit in 22 bits.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STATES; k++) begin
      state_freq[k] <= FREQ_W'(bus_freq) * FREQ_W'(ratio_of(IDX_W'(k)));
    end
    bound_min <= FREQ_W'(bus_freq) * FREQ_W'(ratio_of(IDX_LOWEST));
    bound_max <= FREQ_W'(bus_freq) * FREQ_W'(max_ratio);
  end

  always_comb begin
    cfg.bus_freq     = bus_freq;
    cfg.max_ratio    = max_ratio;
    cfg.driver_ready = driver_ready;
    cfg.state_freq   = state_freq;
    cfg.bound_min    = bound_min;
    cfg.bound_max    = bound_max;
  end

endmodule

`default_nettype wire

// File: sv/crss_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module crss_eval (
  input  wire crss_pkg::cfg_t cfg,
  input  wire crss_pkg::req_t req,
  output crss_pkg::rsp_t      rsp
);
  import crss_pkg::*;

  freq_t       lo_up, hi_up, lo_cut, hi_cut, lo_clamp;
  freq_t       cmp_lo, cmp_hi;
  state_mask_t fit;
  state_mask_t above_lo;
  logic        single_fit;
  state_idx_t  j;
  logic        go;

  // Verify clamping: raise to the lower bound, cut to the upper, then low to high.
  always_comb begin
    lo_up    = (req.low_freq  < cfg.bound_min) ? cfg.bound_min : req.low_freq;
    hi_up    = (req.high_freq < cfg.bound_min) ? cfg.bound_min : req.high_freq;
    lo_cut   = (lo_up > cfg.bound_max) ? cfg.bound_max : lo_up;
    hi_cut   = (hi_up > cfg.bound_max) ? cfg.bound_max : hi_up;
    lo_clamp = (lo_cut > hi_cut) ? hi_cut : lo_cut;
  end

  // One comparator bank serves both actions.
  always_comb begin
    cmp_lo = (req.action == ACT_APPLY) ? req.low_freq  : lo_clamp;
    cmp_hi = (req.action == ACT_APPLY) ? req.high_freq : hi_cut;
    for (int k = 0; k < NUM_STATES; k++) begin
      fit[k]      = (cmp_lo <= cfg.state_freq[k]) && (cmp_hi >= cfg.state_freq[k]);
      above_lo[k] = cfg.state_freq[k] >= lo_clamp;
    end
    single_fit = (fit != '0) && ((fit & (fit - state_mask_t'(1))) == '0);
  end

  always_comb begin
    rsp          = '0;
    rsp.out_low  = req.low_freq;
    rsp.out_high = req.high_freq;
    j            = onehot_index(fit);
    go           = 1'b0;

    if (req.action == ACT_VERIFY) begin
      if (cfg.bus_freq == '0) begin
        rsp.status = ST_NO_ACTION;
      end else begin
        rsp.status  = ST_OK;
        rsp.out_low = lo_clamp;
        if (fit == '0) begin
          // No state in range: lift the high limit to the next state up.
          rsp.out_high = cfg.state_freq[pick_lowest(above_lo, IDX_HIGHEST)];
        end else begin
          rsp.out_high = hi_cut;
        end
      end
    end else if (!cfg.driver_ready) begin
      rsp.status = ST_NOT_READY;
    end else if (single_fit) begin
      go = 1'b1;
    end else if (req.policy_mode == MODE_POWERSAVE ||
                 req.policy_mode == MODE_PERFORMANCE) begin
      j = (req.policy_mode == MODE_POWERSAVE) ? pick_lowest(fit, IDX_HIGHEST)
                                              : pick_highest(fit, IDX_LOWEST);
      if (ratio_of(j) > cfg.max_ratio) begin
        rsp.status      = ST_RATIO_HIGH;
        rsp.state_index = j;
      end else begin
        go = 1'b1;
      end
    end else begin
      rsp.status = ST_NO_ACTION;
    end

    if (go) begin
      rsp.status       = ST_OK;
      rsp.state_index  = j;
      rsp.old_freq     = cfg.state_freq[req.port_read[7:5]];
      rsp.new_freq     = cfg.state_freq[j];
      rsp.control_word = CTRL_FIXED | (CTRL_W'(j) << 5) |
                         CTRL_W'(req.port_read[3:0] & PORT_KEEP);
      rsp.write_port   = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: sv/clock_ratio_state_selector.sv
`timescale 1ns / 1ps
`default_nettype none

// Clock ratio state selector: one frequency policy request in, one result out.
// An accepted request is held in stage one; its result is registered into the
// result register when that register is empty or its result is being taken.
// One request per cycle is sustained while the result side keeps up.
// Synchronous reset empties the pipeline and sets bus_freq 0, max_ratio 60,
// driver_ready 0. Requests see a configuration write once it is registered.
module clock_ratio_state_selector (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire crss_pkg::req_t                   req,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output crss_pkg::rsp_t                        rsp,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [crss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [crss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import crss_pkg::*;

  // Stage one holds the accepted request; stage two is the result register.
  logic   s1_valid;
  req_t   s1_req;
  logic   rsp_load;
  cfg_t   cfg;
  rsp_t   eval_rsp;

  // The configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  // The result register loads when it is empty or its result is being taken.
  // Stage one then moves on; while a result waits, only an empty stage one fills.
  assign rsp_load  = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || rsp_load;

  crss_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // All comparisons and the state choice settle between the two registers.
  // The scaled state table comes registered from the configuration block.
  crss_eval u_eval (
    .cfg (cfg),
    .req (s1_req),
    .rsp (eval_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (rsp_load) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req <= req;
    end
    if (rsp_load && s1_valid) begin
      rsp <= eval_rsp;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_clock_ratio_state_selector.sv
`timescale 1ns / 1ps

module tb_clock_ratio_state_selector;
  import crss_pkg::*;

  // Policy modes that the package leaves unnamed: both mean "leave it alone" but for a lone fit.
  localparam logic [1:0] MODE_HOLD  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int unsigned FREQ_TOP       = 32'h3F_FFFF;
  localparam int unsigned LOWEST_TENTHS  = 20;
  localparam int          PHASES         = 10;
  localparam int          REQS_PER_PHASE = 60;
  // Idle margin after the last result, to cover any slack.
  localparam int          SETTLE_CYCLES  = 6;
  localparam int          LONG_HOLD      = 300;
  localparam int          WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BUS_FREQ;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our own copy of the configuration registers, updated when a write lands.
  int unsigned bus_freq_q  = 0;
  int unsigned max_ratio_q = MAX_RATIO_RESET;
  bit          apply_ok_q  = 1'b0;

  req_t policy_reqs[$];
  rsp_t selections_due[$];

  logic req_taken = 1'b0;
  rsp_t taken_selection = '0;
  bit   drained = 1'b0;
  bit   full_rate = 1'b0;
  int   n_mismatch = 0;
  int   quiet_cycles = 0;

  int   send_burst = 0;
  int   send_gap = 0;
  int   hold_asked = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  pat_pos = '0;

  clock_ratio_state_selector DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clock ratio of each state in tenths, kept apart from the design's table.
  function automatic int unsigned tenths_of(int unsigned k);
    case (k)
      0: return 45;
      1: return 50;
      2: return 40;
      3: return 55;
      4: return 20;
      5: return 30;
      6: return 60;
      default: return 35;
    endcase
  endfunction

  // A state fits when its scaled frequency lies within [lo, hi].
  function automatic bit in_band(int unsigned lo, int unsigned hi, int unsigned k);
    int unsigned f;
    f = bus_freq_q * tenths_of(k);
    return (lo <= f) && (hi >= f);
  endfunction

  // Works out the one result that a request must produce under the
  // current register settings.
  function automatic rsp_t predict_selection(req_t r);
    rsp_t        p;
    int unsigned lo, hi, bmin, bmax, n_fit, pick;
    bit          commit;
    p = '0;
    p.status = ST_OK;
    lo = r.low_freq;
    hi = r.high_freq;
    if (r.action == ACT_VERIFY) begin
      if (bus_freq_q == 0) begin
        // Unknown bus: the limits go back untouched.
        p.status = ST_NO_ACTION;
      end else begin
        // Clamp in a fixed order; the final step keeps low at or below high.
        bmin = LOWEST_TENTHS * bus_freq_q;
        bmax = max_ratio_q * bus_freq_q;
        if (lo < bmin) lo = bmin;
        if (hi < bmin) hi = bmin;
        if (lo > bmax) lo = bmax;
        if (hi > bmax) hi = bmax;
        if (lo > hi) lo = hi;
        n_fit = 0;
        for (int unsigned k = 0; k < NUM_STATES; k++) begin
          if (in_band(lo, hi, k)) n_fit++;
        end
        // Nothing fits: raise high to the slowest state at or above low,
        // or to the top state when none is.
        if (n_fit == 0) begin
          pick = IDX_HIGHEST;
          for (int unsigned k = 0; k < NUM_STATES; k++) begin
            if (tenths_of(k) * bus_freq_q >= lo && tenths_of(k) < tenths_of(pick)) pick = k;
          end
          hi = tenths_of(pick) * bus_freq_q;
        end
      end
    end else if (!apply_ok_q) begin
      p.status = ST_NOT_READY;
    end else begin
      n_fit = 0;
      pick = IDX_LOWEST;
      commit = 1'b1;
      for (int unsigned k = 0; k < NUM_STATES; k++) begin
        if (in_band(lo, hi, k)) begin
          n_fit++;
          pick = k;
        end
      end
      // A lone fit is taken as it is; otherwise the mode decides, and only
      // then is the ratio held against the configured ceiling.
      if (n_fit != 1) begin
        if (r.policy_mode == MODE_POWERSAVE) begin
          pick = IDX_HIGHEST;
          for (int unsigned k = 0; k < NUM_STATES; k++) begin
            if (in_band(lo, hi, k) && tenths_of(k) < tenths_of(pick)) pick = k;
          end
        end else if (r.policy_mode == MODE_PERFORMANCE) begin
          pick = IDX_LOWEST;
          for (int unsigned k = 0; k < NUM_STATES; k++) begin
            if (in_band(lo, hi, k) && tenths_of(k) > tenths_of(pick)) pick = k;
          end
        end else begin
          commit = 1'b0;
          p.status = ST_NO_ACTION;
        end
        if (commit && tenths_of(pick) > max_ratio_q) begin
          commit = 1'b0;
          p.status = ST_RATIO_HIGH;
          p.state_index = IDX_W'(pick);
        end
      end
      if (commit) begin
        p.state_index  = IDX_W'(pick);
        p.old_freq     = FREQ_W'(bus_freq_q * tenths_of(r.port_read[7:5]));
        p.new_freq     = FREQ_W'(bus_freq_q * tenths_of(pick));
        p.control_word = CTRL_FIXED | (CTRL_W'(pick) << 5) | CTRL_W'(r.port_read[3:0] & PORT_KEEP);
        p.write_port   = 1'b1;
      end
    end
    p.out_low  = FREQ_W'(lo);
    p.out_high = FREQ_W'(hi);
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (n_mismatch < 50) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    n_mismatch++;
  endtask

  // Writes one register through the configuration channel and mirrors it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BUS_FREQ:     bus_freq_q  = value;
      CFG_MAX_RATIO:    max_ratio_q = value[RATIO_W-1:0];
      CFG_DRIVER_READY: apply_ok_q  = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The upper bits of the narrow registers are random; the block must drop them.
  task automatic program_policy(input int unsigned bus, input int unsigned ceiling,
                                input bit enable);
    write_reg(CFG_BUS_FREQ, CFG_DATA_W'(bus));
    write_reg(CFG_MAX_RATIO, CFG_DATA_W'(($urandom & 32'hFFC0) | (ceiling & 32'h3F)));
    write_reg(CFG_DRIVER_READY, CFG_DATA_W'(($urandom & 32'hFFFE) | enable));
  endtask

  task automatic queue_req(input logic act, input int unsigned lo, input int unsigned hi,
                           input logic [1:0] mode, input logic [7:0] port);
    req_t r;
    r.action      = act;
    r.low_freq    = FREQ_W'(lo);
    r.high_freq   = FREQ_W'(hi);
    r.policy_mode = mode;
    r.port_read   = port;
    policy_reqs.push_back(r);
  endtask

  // Offsets that land on a state, just beside it, or well away from it.
  function automatic int pick_jitter();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(0, 2) - 1;
      2: return int'($urandom_range(0, 2 * bus_freq_q)) - int'(bus_freq_q);
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  function automatic int unsigned near_state(int unsigned k, int jit);
    longint v;
    v = longint'(bus_freq_q) * tenths_of(k) + jit;
    if (v < 0) v = 0;
    if (v > FREQ_TOP) v = FREQ_TOP;
    return 32'(v);
  endfunction

  // Most random requests place their limits around table states so that
  // every count of fitting states comes up; the rest are raw noise and
  // the field extremes.
  task automatic queue_random_req();
    int unsigned lo, hi, sel;
    logic [1:0]  mode;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: begin
        lo = $urandom & FREQ_TOP;
        hi = $urandom & FREQ_TOP;
      end
      8: begin
        lo = near_state($urandom_range(0, 7), pick_jitter());
        hi = lo;
      end
      9: begin
        lo = ($urandom_range(0, 1) == 0) ? 0 : FREQ_TOP;
        hi = ($urandom_range(0, 1) == 0) ? FREQ_TOP : ($urandom & FREQ_TOP);
      end
      default: begin
        lo = near_state($urandom_range(0, 7), pick_jitter());
        hi = near_state($urandom_range(0, 7), pick_jitter());
      end
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: mode = MODE_POWERSAVE;
      3, 4, 5: mode = MODE_PERFORMANCE;
      6:       mode = MODE_HOLD;
      default: mode = MODE_SPARE;
    endcase
    queue_req(($urandom_range(0, 1) == 0) ? ACT_VERIFY : ACT_APPLY, lo, hi, mode,
              8'($urandom));
  endtask

  // Waits until every request has gone in and every result has come back,
  // then lets the pipeline settle before anything is reconfigured.
  task automatic wait_idle();
    do @(negedge clk); while (!drained);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Request side: bursts of random length separated by random gaps. A valid
  // request is held, payload unchanged, until it is taken.
  always @(negedge clk) begin : feed
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // Still waiting for the block to take the current request.
    end else if (send_gap != 0 && !full_rate) begin
      req_valid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (policy_reqs.size() != 0) begin
      req       <= policy_reqs.pop_front();
      req_valid <= 1'b1;
      if (send_burst != 0) begin
        send_burst <= send_burst - 1;
      end else begin
        send_burst <= $urandom_range(0, 15);
        send_gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      end
    end else begin
      req_valid <= 1'b0;
    end
  end

  // The prediction is made at the edge where the request is taken, while the
  // registers cannot change under it.
  always @(posedge clk) begin : take
    req_taken       <= !rst && req_valid && req_ready;
    taken_selection <= predict_selection(req);
  end

  // Result side: a rotating 16-bit stall pattern that is redrawn each time it wraps,
  // plus an occasional long hold-off counted here.
  always @(negedge clk) begin : drain
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      rsp_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= hold_done + 1;
    end else begin
      rsp_ready <= full_rate ? 1'b1 : stall_pattern[pat_pos];
      pat_pos   <= pat_pos + 1'b1;
      if (pat_pos == 4'hF) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern <= 16'hFFFF;
          1:       stall_pattern <= 16'($urandom);
          2:       stall_pattern <= 16'($urandom | $urandom);
          default: stall_pattern <= 16'($urandom & $urandom);
        endcase
      end
    end
  end

  // Checks each result against the oldest outstanding prediction.
  always @(posedge clk) begin : check
    rsp_t want;
    if (req_taken) selections_due.push_back(taken_selection);
    if (!rst && rsp_valid && rsp_ready) begin
      if (selections_due.size() == 0) begin
        report_mismatch("result with no request outstanding", 32'(rsp.status), 0);
      end else begin
        want = selections_due.pop_front();
        if (rsp.out_low != want.out_low)
          report_mismatch("out_low", rsp.out_low, want.out_low);
        if (rsp.out_high != want.out_high)
          report_mismatch("out_high", rsp.out_high, want.out_high);
        if (rsp.state_index != want.state_index)
          report_mismatch("state_index", rsp.state_index, want.state_index);
        if (rsp.control_word != want.control_word)
          report_mismatch("control_word", rsp.control_word, want.control_word);
        if (rsp.old_freq != want.old_freq)
          report_mismatch("old_freq", rsp.old_freq, want.old_freq);
        if (rsp.new_freq != want.new_freq)
          report_mismatch("new_freq", rsp.new_freq, want.new_freq);
        if (rsp.write_port != want.write_port)
          report_mismatch("write_port", rsp.write_port, want.write_port);
        if (rsp.status != want.status)
          report_mismatch("status", rsp.status, want.status);
      end
    end
    drained <= (policy_reqs.size() == 0) && !req_valid && (selections_due.size() == 0);
  end

  // Ends the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin : watchdog
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned bus, ceiling;
    bit          enable;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Out of reset the bus is unknown and applying is not yet permitted.
    queue_req(ACT_VERIFY, 0, FREQ_TOP, MODE_POWERSAVE, 8'h00);
    queue_req(ACT_APPLY, 123, 456, MODE_PERFORMANCE, 8'hFF);
    wait_idle();

    // With a bus of 1000 the states sit at 20000 through 60000.
    program_policy(1000, 60, 1'b1);
    queue_req(ACT_VERIFY, 0, FREQ_TOP, MODE_POWERSAVE, 8'h00);       // clamp both ends
    queue_req(ACT_VERIFY, 41000, 44000, MODE_POWERSAVE, 8'h00);      // high raised
    queue_req(ACT_VERIFY, FREQ_TOP, 100, MODE_POWERSAVE, 8'h00);     // low pulled under high
    queue_req(ACT_VERIFY, 61000, FREQ_TOP, MODE_PERFORMANCE, 8'h00); // low clamped to the top state
    queue_req(ACT_APPLY, 44000, 46000, MODE_HOLD, 8'hAF);            // lone fit
    queue_req(ACT_APPLY, 0, FREQ_TOP, MODE_POWERSAVE, 8'h5A);
    queue_req(ACT_APPLY, 0, FREQ_TOP, MODE_PERFORMANCE, 8'hE3);
    queue_req(ACT_APPLY, 41000, 44000, MODE_POWERSAVE, 8'h31);       // no fit falls back
    queue_req(ACT_APPLY, 41000, 44000, MODE_PERFORMANCE, 8'h9C);
    queue_req(ACT_APPLY, 0, FREQ_TOP, MODE_HOLD, 8'h77);
    queue_req(ACT_APPLY, 41000, 44000, MODE_SPARE, 8'h00);
    queue_req(ACT_APPLY, 35000, 35000, MODE_PERFORMANCE, 8'hFF);     // exact edge
    wait_idle();

    // A ceiling of 40 blocks the fast states the mode would choose.
    program_policy(1000, 40, 1'b1);
    queue_req(ACT_APPLY, 0, FREQ_TOP, MODE_PERFORMANCE, 8'h12);
    queue_req(ACT_APPLY, 54000, 56000, MODE_POWERSAVE, 8'hC4);       // lone fit is not held back
    queue_req(ACT_APPLY, 41000, 44000, MODE_POWERSAVE, 8'h6B);
    wait_idle();

    // A ceiling under the lowest ratio inverts the clamp window.
    program_policy(1000, 10, 1'b1);
    queue_req(ACT_VERIFY, 0, FREQ_TOP, MODE_POWERSAVE, 8'h00);
    queue_req(ACT_VERIFY, 30000, 35000, MODE_PERFORMANCE, 8'h00);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      bus     = $urandom_range(1, 65535);
      ceiling = $urandom_range(20, 63);
      enable  = 1'b1;
      case (ph)
        0: begin bus = 1000;  ceiling = 60; end
        1: begin bus = 65535; ceiling = 63; end
        2: begin bus = 1;     ceiling = 20; end
        3: ceiling = $urandom_range(0, 63);
        4: bus = 0;
        5: begin bus = 2500;  ceiling = 45; end
        6: ceiling = 0;
        7: enable = 1'b0;
        default: ;
      endcase
      program_policy(bus, ceiling, enable);
      // One phase runs flat out; another starts with the result side held
      // off long enough for the block to back up into its input.
      full_rate = (ph == 3);
      if (ph == 5) hold_asked++;
      repeat (REQS_PER_PHASE) queue_random_req();
      wait_idle();
      full_rate = 1'b0;
    end

    if (selections_due.size() != 0)
      report_mismatch("results never delivered", selections_due.size(), 0);
    if (n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
